// ----- rtl/core/ppad_pkg.sv -----
`default_nettype none

package ppad_pkg;

  localparam int unsigned SampleWidth = 8;
  localparam int unsigned CountWidth  = 8;
  localparam int unsigned LimitWidth  = 7;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CfgDataWidth = 8;

  localparam logic [SampleWidth-1:0] MinReset = 8'd255;
  localparam logic [SampleWidth-1:0] MaxReset = 8'd0;

  localparam logic [7:0]                   SpreadHighReset = 8'd6;
  localparam logic [7:0]                   SpreadLowReset  = 8'd2;
  localparam logic [7:0]                   WindowLastReset = 8'd25;
  localparam logic [LimitWidth-1:0]        CountLimitReset = 7'd20;
  localparam logic signed [CountWidth-1:0] OnLevelReset    = 8'sd10;
  localparam logic signed [CountWidth-1:0] OffLevelReset   = -8'sd10;
  localparam logic signed [CountWidth-1:0] StartCountReset = -8'sd5;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_SPREAD_HIGH = 3'd0,
    CFG_SPREAD_LOW  = 3'd1,
    CFG_WINDOW_LAST = 3'd2,
    CFG_COUNT_LIMIT = 3'd3,
    CFG_ON_LEVEL    = 3'd4,
    CFG_OFF_LEVEL   = 3'd5,
    CFG_START_COUNT = 3'd6
  } cfg_idx_e;

endpackage

`default_nettype wire

// ----- rtl/core/peak_to_peak_activity_detector.sv -----
// Peak-to-peak activity detector.
// Input channel: in_valid_i / in_ready_o with one 8-bit sample_i per transfer.
// Output channel: out_valid_o / out_ready_i with one active_o bit per transfer,
// the activity level after the matching sample, in input order.
// Each input transfer lands in an input register; when the output register is
// free or being read, the running minimum, maximum, window counter, activity
// counter and level update in one pass and the result appears in the output
// register. While the receiver does not stall, throughput is one sample per
// cycle, set by the state update feeding itself.
// When the receiver stalls, the output holds and the input register can still
// take one more sample; only then does in_ready_o fall.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at the
// clock edge and are meant for idle periods; writing start_count loads the
// activity counter; no copy is stored. Unknown indexes are ignored.
// Reset (rst_ni low, asynchronous) restores all registers but sample_q to their
// defaults, empties both stages, sets the minimum to 255, the maximum and window
// count to zero, the counter to the start_count default and the level to idle.
`default_nettype none

module peak_to_peak_activity_detector (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [ppad_pkg::SampleWidth-1:0]     sample_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic                                      active_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [ppad_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  wire logic [ppad_pkg::CfgDataWidth-1:0]    cfg_wdata_i
);
  import ppad_pkg::*;

  logic [7:0]                   spread_high_q, spread_low_q, window_last_q;
  logic [LimitWidth-1:0]        count_limit_q;
  logic signed [CountWidth-1:0] on_level_q, off_level_q;

  logic                         in_valid_q;
  logic [SampleWidth-1:0]       sample_q;
  logic                         out_valid_q;

  logic [SampleWidth-1:0]       run_min_q, run_min_d;
  logic [SampleWidth-1:0]       run_max_q, run_max_d;
  logic [7:0]                   window_count_q, window_count_d;
  logic signed [CountWidth-1:0] activity_count_q, activity_count_d;
  logic                         level_q, level_d;

  logic                         advance;
  logic [SampleWidth-1:0]       new_min, new_max;
  logic signed [SampleWidth:0]  spread;
  logic                         step_up, step_down;
  logic signed [CountWidth:0]   count_wide, limit_pos, limit_neg;
  logic [7:0]                   window_next;
  logic                         window_end;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign active_o    = level_q;

  always_comb begin
    new_max = (sample_q > run_max_q) ? sample_q : run_max_q;
    new_min = (sample_q < run_min_q) ? sample_q : run_min_q;
    spread  = $signed({1'b0, new_max}) - $signed({1'b0, new_min});
    step_up   = spread >= $signed({1'b0, spread_high_q});
    step_down = !step_up && (spread < $signed({1'b0, spread_low_q}));

    limit_pos  = $signed({2'b00, count_limit_q});
    limit_neg  = -limit_pos;
    count_wide = {activity_count_q[CountWidth-1], activity_count_q};
    if (step_up) begin
      count_wide = count_wide + 9'sd1;
      if (count_wide > limit_pos) begin
        count_wide = limit_pos;
      end
    end else if (step_down) begin
      count_wide = count_wide - 9'sd1;
      if (count_wide < limit_neg) begin
        count_wide = limit_neg;
      end
    end
    activity_count_d = count_wide[CountWidth-1:0];

    window_next = window_count_q + 8'd1;
    window_end  = window_next > window_last_q;
    if (window_end) begin
      window_count_d = '0;
      run_min_d      = MinReset;
      run_max_d      = MaxReset;
    end else begin
      window_count_d = window_next;
      run_min_d      = new_min;
      run_max_d      = new_max;
    end

    if (activity_count_d > on_level_q) begin
      level_d = 1'b1;
    end else if (activity_count_d < off_level_q) begin
      level_d = 1'b0;
    end else begin
      level_d = level_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sample_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spread_high_q    <= SpreadHighReset;
      spread_low_q     <= SpreadLowReset;
      window_last_q    <= WindowLastReset;
      count_limit_q    <= CountLimitReset;
      on_level_q       <= OnLevelReset;
      off_level_q      <= OffLevelReset;
      window_count_q   <= '0;
      activity_count_q <= StartCountReset;
      run_min_q        <= MinReset;
      run_max_q        <= MaxReset;
      level_q          <= 1'b0;
    end else begin
      if (advance) begin
        window_count_q   <= window_count_d;
        activity_count_q <= activity_count_d;
        run_min_q        <= run_min_d;
        run_max_q        <= run_max_d;
        level_q          <= level_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SPREAD_HIGH: spread_high_q <= cfg_wdata_i;
          CFG_SPREAD_LOW:  spread_low_q  <= cfg_wdata_i;
          CFG_WINDOW_LAST: window_last_q <= cfg_wdata_i;
          CFG_COUNT_LIMIT: count_limit_q <= cfg_wdata_i[LimitWidth-1:0];
          CFG_ON_LEVEL:    on_level_q    <= $signed(cfg_wdata_i);
          CFG_OFF_LEVEL:   off_level_q   <= $signed(cfg_wdata_i);
          CFG_START_COUNT: activity_count_q <= $signed(cfg_wdata_i);
          default: ;
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled while a stage was free");

  a_window_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !cfg_we_i) |=> (window_count_q <= window_last_q))
    else $error("window count past its last value after an update");

  a_count_upper_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && step_up && !cfg_we_i) |=>
      (activity_count_q <= $signed({1'b0, count_limit_q})))
    else $error("activity counter above its limit after a step up");

  a_result_follows_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("no result after an update");
`endif

endmodule

`default_nettype wire
